// File: rtl/xed_pkg.sv
// Shared types and constants for the XML entity decoder.
// Holds the controller/datapath command and status structs; no dependencies.
package xed_pkg;

  localparam int unsigned ENTITY_WINDOW_DEF = 10;

  // Source of the byte loaded into the output register
  typedef enum logic [2:0] {
    SEL_IN,
    SEL_AMP,
    SEL_SEMI,
    SEL_HEAD,
    SEL_NAMED,
    SEL_CODE
  } emit_sel_t;

  typedef struct packed {
    logic      accept;
    logic      open_win;
    logic      close_win;
    logic      clr_ent;
    logic      set_ent;
    logic      store;
    logic      shift;
    logic      scan_init;
    logic      scan_step;
    logic      emit;
    logic      emit_last;
    emit_sel_t emit_sel;
  } xed_cmd_t;

  typedef struct packed {
    logic out_free;
    logic in_amp;
    logic in_semi;
    logic in_last;
    logic cur_last;
    logic in_entity;
    logic count_zero;
    logic count_one;
    logic win_full;
    logic head_amp;
    logic next_amp;
    logic named_hit;
    logic num_start;
    logic scan_done;
    logic scan_ok;
  } xed_stat_t;

endpackage

// File: rtl/xed_dp.sv
// Datapath of the XML entity decoder: window shift line, numeric scanner,
// named-reference match and output register. Depends on xed_pkg.
module xed_dp #(
  parameter int unsigned ENTITY_WINDOW = xed_pkg::ENTITY_WINDOW_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  xed_pkg::xed_cmd_t   cmd,
  output xed_pkg::xed_stat_t  stat,
  input  logic [7:0]          in_byte,
  input  logic                in_last,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          out_byte,
  output logic                out_last
);

  localparam int unsigned CW = $clog2(ENTITY_WINDOW + 1);
  localparam int unsigned IW = $clog2(ENTITY_WINDOW);
  localparam logic [CW-1:0] FULL_CNT = CW'(ENTITY_WINDOW - 1);

  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_QUOT  = 8'h22;
  localparam logic [7:0] CH_APOS  = 8'h27;
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_G     = 8'h67;
  localparam logic [7:0] CH_L     = 8'h6C;
  localparam logic [7:0] CH_M     = 8'h6D;
  localparam logic [7:0] CH_O     = 8'h6F;
  localparam logic [7:0] CH_P     = 8'h70;
  localparam logic [7:0] CH_Q     = 8'h71;
  localparam logic [7:0] CH_S     = 8'h73;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_XLO   = 8'h78;
  localparam logic [7:0] CH_XUP   = 8'h58;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] VAL_CAP  = 8'd128;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_dec(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return is_dec(c) || (c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] v;
    if (is_dec(c)) v = c - 8'h30;
    else if (c >= 8'h61) v = c - 8'h57;
    else v = c - 8'h37;
    return v[3:0];
  endfunction

  logic [7:0]    win [ENTITY_WINDOW];
  logic [CW-1:0] count;
  logic          in_entity;
  logic          cur_last;

  // numeric scanner
  logic [CW-1:0] scan_pos;
  logic [7:0]    scan_val;
  logic          scan_hex;
  logic          scan_ws;
  logic          scan_neg;
  logic          scan_any;
  logic          scan_zero;
  logic          scan_stop;

  logic [7:0]    scan_ch;
  logic          ch_dig;
  logic [10:0]   prod;
  logic [10:0]   acc;
  logic [7:0]    val_next;
  logic          ch_x;
  logic          base_hex;

  logic          hit_lt, hit_gt, hit_amp, hit_quot, hit_apos;
  logic [7:0]    named_byte;
  logic [7:0]    sel_byte;

  // ---------------- window ----------------
  always_ff @(posedge clk) begin
    if (cmd.store) begin
      win[count[IW-1:0]] <= in_byte;
    end else if (cmd.shift) begin
      for (int k = 0; k < ENTITY_WINDOW - 1; k++) begin
        win[k] <= win[k+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      in_entity <= 1'b0;
      cur_last  <= 1'b0;
    end else begin
      if (cmd.accept) cur_last <= in_last;
      if (cmd.open_win || cmd.set_ent) in_entity <= 1'b1;
      else if (cmd.close_win || cmd.clr_ent) in_entity <= 1'b0;
      if (cmd.open_win || cmd.close_win) count <= '0;
      else if (cmd.store) count <= count + CW'(1);
      else if (cmd.shift) count <= count - CW'(1);
    end
  end

  // ---------------- numeric scanner ----------------
  assign base_hex = (count > CW'(1)) && (win[1] == CH_XLO || win[1] == CH_XUP);
  assign scan_ch  = win[scan_pos[IW-1:0]];
  assign ch_dig   = scan_hex ? is_hex(scan_ch) : is_dec(scan_ch);
  assign ch_x     = (scan_ch == CH_XLO) || (scan_ch == CH_XUP);

  // value stays below 128 whenever it is scaled, so seven bits feed the product
  assign prod = scan_hex ? {scan_val[6:0], 4'h0}
                         : ({1'b0, scan_val[6:0], 3'b000} + {3'b000, scan_val[6:0], 1'b0});
  assign acc  = prod + {7'd0, hex_val(scan_ch)};

  always_comb begin
    if (scan_val[7]) val_next = scan_val;
    else if (acc > {3'd0, VAL_CAP}) val_next = VAL_CAP;
    else val_next = acc[7:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_ws   <= 1'b0;
      scan_neg  <= 1'b0;
      scan_any  <= 1'b0;
      scan_zero <= 1'b0;
      scan_stop <= 1'b0;
    end else if (cmd.scan_init) begin
      scan_ws   <= 1'b1;
      scan_neg  <= 1'b0;
      scan_any  <= 1'b0;
      scan_zero <= 1'b0;
      scan_stop <= 1'b0;
    end else if (cmd.scan_step && !stat.scan_done) begin
      if (scan_ws && is_space(scan_ch)) begin
        scan_ws <= 1'b1;
      end else if (scan_ws && (scan_ch == CH_PLUS || scan_ch == CH_MINUS)) begin
        scan_ws  <= 1'b0;
        scan_neg <= (scan_ch == CH_MINUS);
      end else begin
        scan_ws <= 1'b0;
        if (ch_dig) begin
          scan_any  <= 1'b1;
          scan_zero <= !scan_any && (scan_ch == CH_ZERO);
        end else if (scan_hex && ch_x && scan_zero) begin
          // "0x" prefix after the sign; a lone leading zero leaves the value at 0
          scan_zero <= 1'b0;
        end else begin
          scan_stop <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      scan_pos <= base_hex ? CW'(2) : CW'(1);
      scan_hex <= base_hex;
      scan_val <= '0;
    end else if (cmd.scan_step && !stat.scan_done) begin
      if (scan_ws && (is_space(scan_ch) || scan_ch == CH_PLUS || scan_ch == CH_MINUS)) begin
        scan_pos <= scan_pos + CW'(1);
      end else if (ch_dig) begin
        scan_pos <= scan_pos + CW'(1);
        scan_val <= val_next;
      end else if (scan_hex && ch_x && scan_zero) begin
        scan_pos <= scan_pos + CW'(1);
      end
    end
  end

  // ---------------- named references ----------------
  assign hit_lt   = (count == CW'(2)) && win[0] == CH_L && win[1] == CH_T;
  assign hit_gt   = (count == CW'(2)) && win[0] == CH_G && win[1] == CH_T;
  assign hit_amp  = (count == CW'(3)) && win[0] == CH_A && win[1] == CH_M && win[2] == CH_P;
  assign hit_quot = (count == CW'(4)) && win[0] == CH_Q && win[1] == CH_U &&
                    win[2] == CH_O && win[3] == CH_T;
  assign hit_apos = (count == CW'(4)) && win[0] == CH_A && win[1] == CH_P &&
                    win[2] == CH_O && win[3] == CH_S;

  always_comb begin
    if (hit_lt) named_byte = CH_LT;
    else if (hit_gt) named_byte = CH_GT;
    else if (hit_amp) named_byte = CH_AMP;
    else if (hit_quot) named_byte = CH_QUOT;
    else named_byte = CH_APOS;
  end

  // ---------------- output register ----------------
  always_comb begin
    case (cmd.emit_sel)
      xed_pkg::SEL_IN:    sel_byte = in_byte;
      xed_pkg::SEL_AMP:   sel_byte = CH_AMP;
      xed_pkg::SEL_SEMI:  sel_byte = CH_SEMI;
      xed_pkg::SEL_HEAD:  sel_byte = win[0];
      xed_pkg::SEL_NAMED: sel_byte = named_byte;
      xed_pkg::SEL_CODE:  sel_byte = scan_val;
      default:            sel_byte = in_byte;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_byte <= sel_byte;
      out_last <= cmd.emit_last;
    end
  end

  // ---------------- status ----------------
  always_comb begin
    stat.out_free   = !out_valid || out_ready;
    stat.in_amp     = (in_byte == CH_AMP);
    stat.in_semi    = (in_byte == CH_SEMI);
    stat.in_last    = in_last;
    stat.cur_last   = cur_last;
    stat.in_entity  = in_entity;
    stat.count_zero = (count == '0);
    stat.count_one  = (count == CW'(1));
    stat.win_full   = (count == FULL_CNT);
    stat.head_amp   = (win[0] == CH_AMP);
    stat.next_amp   = (win[1] == CH_AMP);
    stat.named_hit  = hit_lt || hit_gt || hit_amp || hit_quot || hit_apos;
    stat.num_start  = (count != '0) && (win[0] == CH_HASH);
    stat.scan_done  = scan_stop || (scan_pos == count);
    stat.scan_ok    = !scan_neg && (scan_val != '0) && !scan_val[7];
  end

endmodule

// File: rtl/xed_ctrl.sv
// Controller of the XML entity decoder: sequences input handling, reference
// decode, numeric scan and multi-byte emission. Depends on xed_pkg.
module xed_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  xed_pkg::xed_stat_t stat,
  output xed_pkg::xed_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_AMP,
    S_RUN
  } state_t;

  typedef enum logic [1:0] {
    M_FLUSH,
    M_VERB,
    M_OVF
  } mode_t;

  state_t state, state_next;
  mode_t  mode, mode_next;

  assign in_ready = (state == S_IDLE) && stat.out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      mode  <= M_FLUSH;
    end else begin
      state <= state_next;
      mode  <= mode_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    mode_next  = mode;
    case (state)
      S_IDLE: begin
        if (in_valid && stat.out_free) begin
          cmd.accept = 1'b1;
          if (!stat.in_entity) begin
            if (!stat.in_amp) begin
              cmd.emit      = 1'b1;
              cmd.emit_last = 1'b1;
              cmd.emit_sel  = xed_pkg::SEL_IN;
            end else if (stat.in_last) begin
              cmd.emit      = 1'b1;
              cmd.emit_last = 1'b1;
              cmd.emit_sel  = xed_pkg::SEL_AMP;
            end else begin
              cmd.open_win = 1'b1;
            end
          end else if (stat.in_semi) begin
            state_next = S_DECODE;
          end else begin
            cmd.store = 1'b1;
            if (stat.win_full) begin
              mode_next  = M_OVF;
              state_next = S_AMP;
            end else if (stat.in_last) begin
              mode_next  = M_FLUSH;
              state_next = S_AMP;
            end
          end
        end
      end
      S_DECODE: begin
        if (stat.out_free) begin
          if (stat.named_hit) begin
            cmd.emit      = 1'b1;
            cmd.emit_last = 1'b1;
            cmd.emit_sel  = xed_pkg::SEL_NAMED;
            cmd.close_win = 1'b1;
            state_next    = S_IDLE;
          end else if (stat.num_start) begin
            cmd.scan_init = 1'b1;
            state_next    = S_SCAN;
          end else begin
            mode_next  = M_VERB;
            state_next = S_AMP;
          end
        end
      end
      S_SCAN: begin
        if (!stat.scan_done) begin
          cmd.scan_step = 1'b1;
        end else if (!stat.scan_ok) begin
          mode_next  = M_VERB;
          state_next = S_AMP;
        end else if (stat.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_last = 1'b1;
          cmd.emit_sel  = xed_pkg::SEL_CODE;
          cmd.close_win = 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_AMP: begin
        if (stat.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = xed_pkg::SEL_AMP;
          case (mode)
            M_FLUSH: begin
              cmd.emit_last = stat.count_zero;
              if (stat.count_zero) begin
                cmd.close_win = 1'b1;
                state_next    = S_IDLE;
              end else begin
                state_next = S_RUN;
              end
            end
            M_VERB: begin
              state_next = S_RUN;
            end
            M_OVF: begin
              // window closes; held bytes are rescanned as plain text
              cmd.emit_last = stat.head_amp && !stat.cur_last;
              cmd.clr_ent   = 1'b1;
              state_next    = S_RUN;
            end
            default: begin
              state_next = S_RUN;
            end
          endcase
        end
      end
      S_RUN: begin
        if (stat.out_free) begin
          case (mode)
            M_FLUSH: begin
              cmd.emit      = 1'b1;
              cmd.emit_sel  = xed_pkg::SEL_HEAD;
              cmd.emit_last = stat.count_one;
              cmd.shift     = 1'b1;
              if (stat.count_one) begin
                cmd.close_win = 1'b1;
                state_next    = S_IDLE;
              end
            end
            M_VERB: begin
              cmd.emit = 1'b1;
              if (stat.count_zero) begin
                cmd.emit_sel  = xed_pkg::SEL_SEMI;
                cmd.emit_last = 1'b1;
                cmd.close_win = 1'b1;
                state_next    = S_IDLE;
              end else begin
                cmd.emit_sel = xed_pkg::SEL_HEAD;
                cmd.shift    = 1'b1;
              end
            end
            M_OVF: begin
              cmd.shift = 1'b1;
              if (stat.head_amp) begin
                // a held ampersand reopens the window with the rest
                cmd.set_ent = 1'b1;
                if (stat.cur_last) begin
                  mode_next  = M_FLUSH;
                  state_next = S_AMP;
                end else begin
                  state_next = S_IDLE;
                end
              end else begin
                cmd.emit      = 1'b1;
                cmd.emit_sel  = xed_pkg::SEL_HEAD;
                cmd.emit_last = stat.count_one || (stat.next_amp && !stat.cur_last);
                if (stat.count_one) state_next = S_IDLE;
              end
            end
            default: begin
              cmd.close_win = 1'b1;
              state_next    = S_IDLE;
            end
          endcase
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/xml_entity_decoder.sv
// A plain byte shows on m_tdata the cycle after its transfer; one per cycle while the
// output is free. A closing ';' enters a decode state, then, for numeric forms, a scan
// state over the window bytes; verbatim, overflow and end-of-text runs emit byte by byte.
// Input waits in decode, scan or a multi-byte run, or while the output register is held.
// Reset (rst, synchronous): window closed, fill count zero, output register empty.
module xml_entity_decoder #(
  parameter int unsigned ENTITY_WINDOW = xed_pkg::ENTITY_WINDOW_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] in_byte
  input  logic       s_tlast,   // in_last
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_byte
  output logic       m_tlast    // out_last
);

  xed_pkg::xed_cmd_t  cmd;
  xed_pkg::xed_stat_t stat;

  xed_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  xed_dp #(
    .ENTITY_WINDOW (ENTITY_WINDOW)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_byte   (s_tdata),
    .in_last   (s_tlast),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_byte  (m_tdata),
    .out_last  (m_tlast)
  );

endmodule

// File: rtl/xed_checker.sv
// Port-level checks for the XML entity decoder, bound to the top level.
// Depends only on the top-level ports.
module xed_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic [7:0] s_tdata,
  input logic       s_tlast,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tlast
);

  // output register is empty after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  // a stalled result transfer holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output changed while stalled");

  // input is only taken when the output register can take a result
  a_ready_room: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !m_tvalid || m_tready)
    else $error("input ready while output blocked");

  // an offered input transfer holds until taken
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tlast))
    else $error("input changed while stalled");

endmodule

bind xml_entity_decoder xed_checker u_xed_checker (.*);
